// ----- rtl/core/iwfg_pkg.sv -----
// Shared types, codes and constant tables of the idle-weighted frequency governor.
`default_nettype none

package iwfg_pkg;

    localparam int HISTORY_DEPTH  = 5;
    localparam int DEF_NUM_CPUS   = 4;
    localparam int DEF_MAX_STATES = 8;

    localparam int PCT_W      = 7;
    localparam int FREQ_W     = 32;
    localparam int CNT_OUT_W  = 3;
    localparam int TIDX_W     = 6;
    localparam int SC_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOT_W     = 3;
    localparam int WEIGHT_W   = 8;
    localparam int BSTEP_W    = 7;
    localparam int CODE_W     = 2;

    typedef logic [PCT_W-1:0]  pct_t;
    typedef logic [FREQ_W-1:0] freq_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_THRESHOLD,
        CFG_STATE_COUNT,
        CFG_MAX_FREQUENCY,
        CFG_MIN_FREQUENCY
    } cfg_idx_t;

    typedef enum logic {
        CMD_TICK,
        CMD_TABLE_WRITE
    } cmd_t;

    typedef enum logic [CODE_W-1:0] {
        ACT_SET,
        ACT_HOLD,
        ACT_DEFER
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        BREQ_NONE,
        BREQ_DISABLE,
        BREQ_ENABLE
    } breq_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CPU,
        ST_BUCKET,
        ST_LOOKUP,
        ST_READ
    } state_t;

    localparam freq_t WORD_BOOST    = 32'hFFFF_FFFF;
    localparam freq_t WORD_MIN      = 32'hFFFF_FFFE;
    localparam freq_t WORD_ONDEMAND = 32'h0000_0000;

    localparam pct_t              RST_IDLE_THRESHOLD = 7'd90;
    localparam logic [SC_W-1:0]   RST_STATE_COUNT    = 4'd4;

    // Weight sum for 1..5 filled history entries.
    function automatic logic [WEIGHT_W-1:0] weight_sum(input logic [SLOT_W-1:0] size);
        logic [WEIGHT_W-1:0] w;
        begin
            case (size)
                3'd1:    w = 8'd100;
                3'd2:    w = 8'd150;
                3'd3:    w = 8'd175;
                3'd4:    w = 8'd187;
                default: w = 8'd193;
            endcase
            return w;
        end
    endfunction

    // Load bucket width, 100 / n, for n = 1..15.
    function automatic logic [BSTEP_W-1:0] bucket_step(input logic [SC_W-1:0] n);
        logic [BSTEP_W-1:0] q;
        begin
            case (n)
                4'd2:    q = 7'd50;
                4'd3:    q = 7'd33;
                4'd4:    q = 7'd25;
                4'd5:    q = 7'd20;
                4'd6:    q = 7'd16;
                4'd7:    q = 7'd14;
                4'd8:    q = 7'd12;
                4'd9:    q = 7'd11;
                4'd10:   q = 7'd10;
                4'd11:   q = 7'd9;
                4'd12:   q = 7'd8;
                4'd13:   q = 7'd7;
                4'd14:   q = 7'd7;
                4'd15:   q = 7'd6;
                default: q = 7'd100;
            endcase
            return q;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/idle_weighted_freq_governor_top.sv -----
// Top level of the idle-weighted frequency governor: sequencer, history, table lookup.
//
//  channel | signals                        | direction | transfer
//  --------+--------------------------------+-----------+---------------------------
//  cfg     | cfg_we, cfg_index, cfg_data    | in        | write when cfg_we is high
//  in      | in_valid/in_ready + fields     | in        | valid & ready
//  out     | out_valid/out_ready + fields   | out       | valid & ready
//
//  A table write item is written into the table RAM as it is accepted. A tick steps once
//  per CPU through the shared history adder and threshold compare, then through 1..n
//  bucket steps, then the table RAM read. The table RAM has one read port.
//  Reset returns control state to its defaults; history and table stay undefined until written.
//  The result sits in an output register; a new item is accepted while it waits, and the
//  sequencer holds in its last step while an earlier result is still not taken.
`default_nettype none

module idle_weighted_freq_governor_top #(
    parameter int NUM_CPUS   = iwfg_pkg::DEF_NUM_CPUS,
    parameter int MAX_STATES = iwfg_pkg::DEF_MAX_STATES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [iwfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [iwfg_pkg::FREQ_W-1:0]      cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic [iwfg_pkg::PCT_W-1:0]       load_percent,
    input  wire logic                             boost_active,
    input  wire logic [iwfg_pkg::FREQ_W-1:0]      current_frequency,
    input  wire logic [iwfg_pkg::PCT_W-1:0]       idle_cpu0,
    input  wire logic [iwfg_pkg::PCT_W-1:0]       idle_cpu1,
    input  wire logic [iwfg_pkg::PCT_W-1:0]       idle_cpu2,
    input  wire logic [iwfg_pkg::PCT_W-1:0]       idle_cpu3,
    input  wire logic [iwfg_pkg::TIDX_W-1:0]      table_index,
    input  wire logic [iwfg_pkg::FREQ_W-1:0]      table_value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [iwfg_pkg::CODE_W-1:0]           action,
    output logic [iwfg_pkg::FREQ_W-1:0]           target_frequency,
    output logic [iwfg_pkg::CODE_W-1:0]           boost_request,
    output logic [iwfg_pkg::CNT_OUT_W-1:0]        idle_cpu_count
);

    import iwfg_pkg::*;

    localparam int TABLE_DEPTH = MAX_STATES * (NUM_CPUS + 1);
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CPU_W       = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IDLE_W      = $clog2(NUM_CPUS + 1);
    localparam int BKT_W       = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int SUM_W       = $clog2(HISTORY_DEPTH * (2 ** PCT_W - 1) + 1);
    localparam int SCALED_W    = $clog2(HISTORY_DEPTH * (2 ** PCT_W - 1) * 100 + 1);
    localparam int LK_W        = SC_W + IDLE_W + 1;
    localparam int P_W         = BSTEP_W + 1;

    typedef pct_t hist_row_t [HISTORY_DEPTH];

    // control state
    state_t                 state_reg, state_next;
    pct_t                   thr_reg;
    logic [SC_W-1:0]        sc_reg;
    freq_t                  fmax_reg;
    freq_t                  fmin_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      fill_reg;
    logic [HISTORY_DEPTH-1:0] bhist_reg;
    logic [CPU_W-1:0]       cpu_idx_reg;
    logic [IDLE_W-1:0]      idle_cnt_reg;
    logic [BKT_W-1:0]       bucket_reg;
    logic [P_W-1:0]         p_reg;
    logic                   out_valid_reg;

    // item payload
    pct_t                   load_reg;
    logic                   boost_on_reg;
    freq_t                  cur_reg;
    pct_t                   sample_reg [NUM_CPUS];
    logic [SC_W-1:0]        n_reg;
    logic [SCALED_W-1:0]    thrw_reg;
    logic [SLOT_W-1:0]      size_reg;
    logic [SLOT_W-1:0]      cur_slot_reg;
    hist_row_t              hist_reg [NUM_CPUS];
    logic [CODE_W-1:0]      action_reg;
    freq_t                  freq_reg;
    logic [CODE_W-1:0]      breq_reg;
    logic [CNT_OUT_W-1:0]   count_reg;

    logic                   tick_accept;
    logic                   wr_accept;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ADDR_W-1:0]      ram_raddr;
    freq_t                  ram_rdata;
    logic                   cpu_last;
    logic                   bucket_done;
    logic                   out_load;

    logic [SLOT_W-1:0]      fill_new;
    logic [SLOT_W-1:0]      slot_new;
    logic [SC_W-1:0]        n_new;
    logic [SCALED_W-1:0]    thrw_new;

    hist_row_t              row_new;
    logic [SUM_W-1:0]       hist_sum;
    logic [SCALED_W-1:0]    scaled_sum;
    logic                   cpu_idle;
    logic [LK_W-1:0]        lk_full;

    logic                   is_boost;
    logic                   is_min;
    logic                   is_ondemand;
    logic [HISTORY_DEPTH-1:0] bhist_new;
    logic [SLOT_W-1:0]      bh_ones;
    freq_t                  freq_sel;
    logic [CODE_W-1:0]      act_sel;
    logic [CODE_W-1:0]      breq_sel;

    iwfg_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (table_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // accept-cycle values
    always_comb
    begin
        fill_new = (int'(fill_reg) < HISTORY_DEPTH) ? fill_reg + SLOT_W'(1) : fill_reg;
        slot_new = (int'(slot_reg) == HISTORY_DEPTH - 1) ? '0 : slot_reg + SLOT_W'(1);
        if (sc_reg == '0)
        begin
            n_new = SC_W'(1);
        end
        else if (int'(sc_reg) > MAX_STATES)
        begin
            n_new = SC_W'(MAX_STATES);
        end
        else
        begin
            n_new = sc_reg;
        end
        thrw_new = SCALED_W'({1'b0, thr_reg} + 8'd1) * SCALED_W'(weight_sum(fill_new));
    end

    // shared history step: store sample, sum filled entries, halve them, compare
    always_comb
    begin
        hist_row_t row;
        pct_t      e;
        row      = hist_reg[cpu_idx_reg];
        hist_sum = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            e = (SLOT_W'(k) == cur_slot_reg) ? sample_reg[cpu_idx_reg] : row[k];
            if (SLOT_W'(k) < size_reg)
            begin
                hist_sum   = hist_sum + SUM_W'(e);
                row_new[k] = e >> 1;
            end
            else
            begin
                row_new[k] = row[k];
            end
        end
        scaled_sum = SCALED_W'(hist_sum) * SCALED_W'(100);
        cpu_idle   = (scaled_sum >= thrw_reg);
    end

    assign cpu_last    = (cpu_idx_reg == CPU_W'(NUM_CPUS - 1));
    assign bucket_done = ({1'b0, load_reg} <= p_reg) ||
                         (SC_W'(bucket_reg) == n_reg - SC_W'(1));
    assign lk_full     = LK_W'(n_reg) * LK_W'(idle_cnt_reg) + LK_W'(bucket_reg);

    // decision on the table word
    always_comb
    begin
        is_boost    = (ram_rdata == WORD_BOOST);
        is_min      = (ram_rdata == WORD_MIN);
        is_ondemand = (ram_rdata == WORD_ONDEMAND);
        if (is_boost)
        begin
            bhist_new = bhist_reg | (HISTORY_DEPTH'(1) << cur_slot_reg);
        end
        else
        begin
            bhist_new = bhist_reg & ~(HISTORY_DEPTH'(1) << cur_slot_reg);
        end
        bh_ones = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            bh_ones = bh_ones + SLOT_W'(bhist_new[k]);
        end
        breq_sel = BREQ_NONE;
        if (boost_on_reg && (bhist_new == '0))
        begin
            breq_sel = BREQ_DISABLE;
        end
        if (!boost_on_reg && (int'(bh_ones) == HISTORY_DEPTH - 1))
        begin
            breq_sel = BREQ_ENABLE;
        end
        if (is_ondemand)
        begin
            freq_sel = '0;
            act_sel  = ACT_DEFER;
        end
        else
        begin
            if (is_boost)
            begin
                freq_sel = fmax_reg;
            end
            else if (is_min)
            begin
                freq_sel = fmin_reg;
            end
            else
            begin
                freq_sel = ram_rdata;
            end
            act_sel = (cur_reg == freq_sel) ? ACT_HOLD : ACT_SET;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = ST_CPU;
                end
            end
            ST_CPU:
            begin
                if (cpu_last)
                begin
                    state_next = ST_BUCKET;
                end
            end
            ST_BUCKET:
            begin
                if (bucket_done)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        tick_accept = in_valid && in_ready && (command == CMD_TICK);
        wr_accept   = in_valid && in_ready && (command == CMD_TABLE_WRITE);
        ram_we      = wr_accept && (int'(table_index) < TABLE_DEPTH);
        ram_waddr   = ADDR_W'(table_index);
        ram_raddr   = ADDR_W'(lk_full);
        out_load    = (state_reg == ST_READ) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= RST_IDLE_THRESHOLD;
            sc_reg        <= RST_STATE_COUNT;
            fmax_reg      <= '0;
            fmin_reg      <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            bhist_reg     <= '0;
            cpu_idx_reg   <= '0;
            idle_cnt_reg  <= '0;
            bucket_reg    <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_IDLE_THRESHOLD: thr_reg  <= cfg_data[PCT_W-1:0];
                    CFG_STATE_COUNT:    sc_reg   <= cfg_data[SC_W-1:0];
                    CFG_MAX_FREQUENCY:  fmax_reg <= cfg_data;
                    CFG_MIN_FREQUENCY:  fmin_reg <= cfg_data;
                    default:            thr_reg  <= thr_reg;
                endcase
            end
            if (tick_accept)
            begin
                slot_reg     <= slot_new;
                fill_reg     <= fill_new;
                cpu_idx_reg  <= '0;
                idle_cnt_reg <= '0;
                bucket_reg   <= '0;
                p_reg        <= P_W'(bucket_step(n_new));
            end
            if (state_reg == ST_CPU)
            begin
                cpu_idx_reg  <= cpu_idx_reg + CPU_W'(1);
                idle_cnt_reg <= idle_cnt_reg + IDLE_W'(cpu_idle);
            end
            if ((state_reg == ST_BUCKET) && !bucket_done)
            begin
                bucket_reg <= bucket_reg + BKT_W'(1);
                p_reg      <= p_reg + P_W'(bucket_step(n_reg));
            end
            if (out_load)
            begin
                bhist_reg     <= bhist_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            load_reg     <= load_percent;
            boost_on_reg <= boost_active;
            cur_reg      <= current_frequency;
            n_reg        <= n_new;
            thrw_reg     <= thrw_new;
            size_reg     <= fill_new;
            cur_slot_reg <= slot_reg;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                if (i == 0)
                begin
                    sample_reg[i] <= idle_cpu0;
                end
                else if (i == 1)
                begin
                    sample_reg[i] <= idle_cpu1;
                end
                else if (i == 2)
                begin
                    sample_reg[i] <= idle_cpu2;
                end
                else if (i == 3)
                begin
                    sample_reg[i] <= idle_cpu3;
                end
                else
                begin
                    sample_reg[i] <= '0;
                end
            end
        end
        if (state_reg == ST_CPU)
        begin
            hist_reg[cpu_idx_reg] <= row_new;
        end
        if (out_load)
        begin
            action_reg <= act_sel;
            freq_reg   <= freq_sel;
            breq_reg   <= breq_sel;
            count_reg  <= CNT_OUT_W'(idle_cnt_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign action           = action_reg;
    assign target_frequency = freq_reg;
    assign boost_request    = breq_reg;
    assign idle_cpu_count   = count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/iwfg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iwfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
